/* rtl/exp3_pkg.sv */
// ============================================================================
// EXP3-IX arm selector package
// Shared widths, state and command types and the exponential table builder.
// ============================================================================
`default_nettype none

package exp3_pkg;

    // Default arm capacity of the top level.
    localparam int ARM_CAPACITY_DEF = 16;

    // Field and storage widths.
    localparam int WEIGHT_W   = 32;
    localparam int PROB_W     = 17;
    localparam int EXP_VAL_W  = 17;
    localparam int EXP_IDX_W  = 10;
    localparam int EXP_ENTRIES = 1024;
    localparam int SUM_W      = 25;
    localparam int NUM_W      = 35;
    localparam int DEN_W      = 25;
    localparam int ARG_W      = 48;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LEARNING_RATE    = 2'd0;
    localparam logic [1:0] CFG_EXPLORATION_BIAS = 2'd1;
    localparam logic [1:0] CFG_ACTIVE_ARMS      = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] LEARNING_RATE_RST    = 16'd6554;
    localparam logic [15:0] EXPLORATION_BIAS_RST = 16'd13107;
    localparam logic [4:0]  ACTIVE_ARMS_RST      = 5'd16;

    // Step of the exponential table in Q0.32: exp(-1/64).
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4228380000;

    typedef logic [EXP_VAL_W-1:0] exp_rom_t [EXP_ENTRIES];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIN_REQ,
        ST_MIN_USE,
        ST_EXP_REQ,
        ST_EXP_MUL,
        ST_EXP_ROM,
        ST_EXP_ACC,
        ST_NRM_REQ,
        ST_NRM_DIV,
        ST_NRM_WAIT,
        ST_NRM_WR,
        ST_RW_REQ,
        ST_RW_DEN,
        ST_RW_WAIT,
        ST_RW_UPD,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clr_idx;
        logic inc_idx;
        logic min_upd;
        logic exp_mul;
        logic exp_rom;
        logic exp_acc;
        logic nrm_div_start;
        logic nrm_write;
        logic rw_den;
        logic rw_div_start;
        logic rw_update;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_last_k;
        logic idx_ge_k;
        logic idx_last_cap;
        logic arm_ok;
        logic den_zero;
        logic div_done;
        logic out_free;
    } status_t;

    // Rounded Q0.32 product.
    function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        begin
            p = a * b;
            mul_q32 = (p >> 32) + {63'd0, p[31]};
        end
    endfunction

    // Table of exp(-j/64) in Q1.16, built by square and multiply.
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] acc;
        logic [63:0] base;
        logic [63:0] rnd;
        begin
            for (int j = 0; j < EXP_ENTRIES; j++)
            begin
                acc  = 64'h1_0000_0000;
                base = EXP_STEP_Q32;
                for (int b = 0; b < EXP_IDX_W; b++)
                begin
                    if (((j >> b) & 1) != 0)
                    begin
                        acc = mul_q32(acc, base);
                    end
                    base = mul_q32(base, base);
                end
                rnd = (acc + 64'h8000) >> 16;
                rom[j] = rnd[EXP_VAL_W-1:0];
            end
            build_exp_rom = rom;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/exp3_div.sv */
// ============================================================================
// EXP3-IX restoring divider
// Shared unsigned divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module exp3_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [exp3_pkg::NUM_W-1:0] num,
    input  wire logic [exp3_pkg::DEN_W-1:0] den,
    output logic                            done,
    output logic [exp3_pkg::NUM_W-1:0]      quot
);

    localparam int NW = exp3_pkg::NUM_W;
    localparam int DW = exp3_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   shifted;
    logic          fits;

    // One restoring step.
    always_comb
    begin
        shifted   = {rem_reg[DW-1:0], q_reg[NW-1]};
        fits      = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            q_next    = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (shifted - {1'b0, den_reg}) : shifted;
            q_next   = {q_reg[NW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

/* rtl/exp3_dp.sv */
// ============================================================================
// EXP3-IX datapath
// Weight, probability and exponent stores, arithmetic and result register.
// ============================================================================
`default_nettype none

module exp3_dp #(
    parameter int ARM_CAPACITY = exp3_pkg::ARM_CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire exp3_pkg::cmd_t    cmd,
    output exp3_pkg::status_t      status,
    input  wire logic              cfg_valid,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              kind,
    input  wire logic [3:0]        arm_index,
    input  wire logic [16:0]       reward_value,
    input  wire logic [15:0]       uniform_draw,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [3:0]             chosen_arm,
    output logic                   saturated
);

    localparam int AW = $clog2(ARM_CAPACITY);
    localparam int WW = exp3_pkg::WEIGHT_W;
    localparam int PW = exp3_pkg::PROB_W;
    localparam int EW = exp3_pkg::EXP_VAL_W;
    localparam int SW = exp3_pkg::SUM_W;
    localparam int NW = exp3_pkg::NUM_W;
    localparam int DW = exp3_pkg::DEN_W;
    localparam int GW = exp3_pkg::ARG_W;
    localparam int XW = exp3_pkg::EXP_IDX_W;
    localparam logic [8:0] CAP9 = 9'(ARM_CAPACITY);
    localparam exp3_pkg::exp_rom_t EXP_ROM = exp3_pkg::build_exp_rom();

    // Configuration registers.
    logic [15:0] learning_rate_reg;
    logic [15:0] exploration_bias_reg;
    logic [4:0]  active_arms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learning_rate_reg    <= exp3_pkg::LEARNING_RATE_RST;
            exploration_bias_reg <= exp3_pkg::EXPLORATION_BIAS_RST;
            active_arms_reg      <= exp3_pkg::ACTIVE_ARMS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                exp3_pkg::CFG_LEARNING_RATE:    learning_rate_reg    <= cfg_data;
                exp3_pkg::CFG_EXPLORATION_BIAS: exploration_bias_reg <= cfg_data;
                exp3_pkg::CFG_ACTIVE_ARMS:      active_arms_reg      <= cfg_data[4:0];
                default:                        ;
            endcase
        end
    end

    // Effective number of active arms.
    logic [8:0] aa9;
    logic [8:0] k9;
    logic [8:0] km1_9;

    always_comb
    begin
        aa9 = {4'd0, active_arms_reg};
        if (aa9 == 9'd0)
        begin
            k9 = 9'd1;
        end
        else if (aa9 > CAP9)
        begin
            k9 = CAP9;
        end
        else
        begin
            k9 = aa9;
        end
        km1_9 = k9 - 9'd1;
    end

    // Captured item and sequencing registers.
    logic          rw_mode_reg;
    logic [3:0]    arm_reg;
    logic [16:0]   reward_reg;
    logic [15:0]   draw_reg;
    logic [AW-1:0] idx_reg;
    logic [8:0]    idx9;
    logic [8:0]    arm9;
    logic [AW-1:0] rd_addr;

    assign idx9    = {{(9 - AW){1'b0}}, idx_reg};
    assign arm9    = {5'd0, arm_reg};
    assign rd_addr = rw_mode_reg ? arm9[AW-1:0] : idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_mode_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                rw_mode_reg <= kind;
            end
            if (cmd.clr_idx)
            begin
                idx_reg <= '0;
            end
            else if (cmd.inc_idx)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            arm_reg    <= arm_index;
            reward_reg <= reward_value;
            draw_reg   <= uniform_draw;
        end
    end

    // Weight store with valid bits.
    logic [WW-1:0]           w_mem [ARM_CAPACITY];
    logic [ARM_CAPACITY-1:0] w_vld_reg;
    logic [WW-1:0]           w_rd_reg;
    logic                    w_rd_vld_reg;
    logic [WW-1:0]           w_q;
    logic [WW-1:0]           w_new;

    always_ff @(posedge clk)
    begin
        if (cmd.rw_update)
        begin
            w_mem[rd_addr] <= w_new;
        end
        w_rd_reg <= w_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_vld_reg    <= '0;
            w_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rw_update)
            begin
                w_vld_reg[rd_addr] <= 1'b1;
            end
            w_rd_vld_reg <= w_vld_reg[rd_addr];
        end
    end

    assign w_q = w_rd_vld_reg ? w_rd_reg : '0;

    // Probability store with valid bits.
    logic [PW-1:0]           p_mem [ARM_CAPACITY];
    logic [ARM_CAPACITY-1:0] p_vld_reg;
    logic [PW-1:0]           p_rd_reg;
    logic                    p_rd_vld_reg;
    logic [PW-1:0]           p_q;
    logic [PW-1:0]           p_new;

    always_ff @(posedge clk)
    begin
        if (cmd.nrm_write)
        begin
            p_mem[idx_reg] <= p_new;
        end
        p_rd_reg <= p_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg    <= '0;
            p_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.nrm_write)
            begin
                p_vld_reg[idx_reg] <= 1'b1;
            end
            p_rd_vld_reg <= p_vld_reg[rd_addr];
        end
    end

    assign p_q = p_rd_vld_reg ? p_rd_reg : '0;

    // Exponent store, always written before it is read within a choose.
    logic [EW-1:0] e_mem [ARM_CAPACITY];
    logic [EW-1:0] e_rd_reg;
    logic [EW-1:0] e_val;

    always_ff @(posedge clk)
    begin
        if (cmd.exp_acc)
        begin
            e_mem[idx_reg] <= e_val;
        end
        e_rd_reg <= e_mem[idx_reg];
    end

    // Minimum weight over the active arms.
    logic [WW-1:0] wmin_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.min_upd && ((idx_reg == '0) || (w_q < wmin_reg)))
        begin
            wmin_reg <= w_q;
        end
    end

    // Exponent argument, table lookup and running sum.
    logic [GW-1:0] arg_reg;
    logic [EW-1:0] rom_q_reg;
    logic          big_reg;
    logic [SW-1:0] sum_reg;
    logic [XW-1:0] rom_addr;

    assign rom_addr = arg_reg[XW+25:26];
    assign e_val    = big_reg ? '0 : rom_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.exp_mul)
        begin
            arg_reg <= GW'(learning_rate_reg) * GW'(w_q - wmin_reg);
        end
        if (cmd.exp_rom)
        begin
            rom_q_reg <= EXP_ROM[rom_addr];
            big_reg   <= |arg_reg[GW-1:XW+26];
        end
        if (cmd.exp_acc)
        begin
            sum_reg <= ((idx_reg == '0) ? '0 : sum_reg) + SW'(e_val);
        end
    end

    // Shared divider.
    logic [16:0]   r_clip;
    logic [16:0]   loss;
    logic [17:0]   den_rw;
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic [NW-1:0] quot;
    logic          div_done;

    always_comb
    begin
        r_clip = (reward_reg > 17'd65536) ? 17'd65536 : reward_reg;
        loss   = 17'd65536 - r_clip;
        den_rw = {1'b0, p_q} + {2'd0, exploration_bias_reg};
        if (rw_mode_reg)
        begin
            div_num = {2'd0, loss, 16'd0};
            div_den = DW'(den_rw);
        end
        else
        begin
            div_num = {2'd0, e_rd_reg, 16'd0} + NW'(sum_reg >> 1);
            div_den = sum_reg;
        end
    end

    exp3_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.nrm_div_start | cmd.rw_div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    // Normalisation and sampling.
    logic [SW-1:0] cum_reg;
    logic [SW-1:0] cum_new;
    logic          found_reg;
    logic [AW-1:0] chosen_reg;
    logic          sat_reg;
    logic          idx_ge_k;

    assign idx_ge_k = idx9 >= k9;
    assign p_new    = idx_ge_k ? '0 : quot[PW-1:0];
    assign cum_new  = cum_reg + SW'(p_new);

    // Reward update.
    logic          den_zero_reg;
    logic [WW-1:0] est;
    logic          est_sat;
    logic [WW:0]   total;

    always_comb
    begin
        if (den_zero_reg)
        begin
            est     = '1;
            est_sat = 1'b1;
        end
        else if (|quot[NW-1:WW])
        begin
            est     = '1;
            est_sat = 1'b1;
        end
        else
        begin
            est     = quot[WW-1:0];
            est_sat = 1'b0;
        end
        total = {1'b0, w_q} + {1'b0, est};
        w_new = total[WW] ? '1 : total[WW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rw_den)
        begin
            den_zero_reg <= den_rw == 18'd0;
        end
        if (cmd.accept)
        begin
            cum_reg    <= '0;
            found_reg  <= 1'b0;
            sat_reg    <= 1'b0;
            chosen_reg <= kind ? '0 : km1_9[AW-1:0];
        end
        else if (cmd.nrm_write)
        begin
            if (!idx_ge_k && !found_reg)
            begin
                cum_reg <= cum_new;
                if (cum_new > SW'(draw_reg))
                begin
                    chosen_reg <= idx_reg;
                    found_reg  <= 1'b1;
                end
            end
        end
        else if (cmd.rw_update)
        begin
            sat_reg <= est_sat | total[WW];
        end
    end

    // Result register.
    logic        out_valid_reg;
    logic [3:0]  chosen_out_reg;
    logic        sat_out_reg;
    logic [8:0]  chosen9;

    assign chosen9 = {{(9 - AW){1'b0}}, chosen_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            chosen_out_reg <= chosen9[3:0];
            sat_out_reg    <= sat_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign chosen_arm = chosen_out_reg;
    assign saturated  = sat_out_reg;

    // Status to the controller.
    always_comb
    begin
        status.idx_last_k   = idx9 == km1_9;
        status.idx_ge_k     = idx_ge_k;
        status.idx_last_cap = idx9 == (CAP9 - 9'd1);
        status.arm_ok       = arm9 < k9;
        status.den_zero     = den_rw == 18'd0;
        status.div_done     = div_done;
        status.out_free     = !out_valid_reg || !out_stall;
    end

endmodule

`default_nettype wire

/* rtl/exp3_ctrl.sv */
// ============================================================================
// EXP3-IX controller
// Sequencer that walks the arms for a choose and runs a reward update.
// ============================================================================
`default_nettype none

module exp3_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                kind,
    input  wire exp3_pkg::status_t   status,
    output exp3_pkg::cmd_t           cmd,
    output logic                     in_stall
);

    exp3_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= exp3_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            exp3_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = kind ? exp3_pkg::ST_RW_REQ : exp3_pkg::ST_MIN_REQ;
                end
            exp3_pkg::ST_MIN_REQ:  state_next = exp3_pkg::ST_MIN_USE;
            exp3_pkg::ST_MIN_USE:
                state_next = status.idx_last_k ? exp3_pkg::ST_EXP_REQ : exp3_pkg::ST_MIN_REQ;
            exp3_pkg::ST_EXP_REQ:  state_next = exp3_pkg::ST_EXP_MUL;
            exp3_pkg::ST_EXP_MUL:  state_next = exp3_pkg::ST_EXP_ROM;
            exp3_pkg::ST_EXP_ROM:  state_next = exp3_pkg::ST_EXP_ACC;
            exp3_pkg::ST_EXP_ACC:
                state_next = status.idx_last_k ? exp3_pkg::ST_NRM_REQ : exp3_pkg::ST_EXP_REQ;
            exp3_pkg::ST_NRM_REQ:
                state_next = status.idx_ge_k ? exp3_pkg::ST_NRM_WR : exp3_pkg::ST_NRM_DIV;
            exp3_pkg::ST_NRM_DIV:  state_next = exp3_pkg::ST_NRM_WAIT;
            exp3_pkg::ST_NRM_WAIT:
                if (status.div_done)
                begin
                    state_next = exp3_pkg::ST_NRM_WR;
                end
            exp3_pkg::ST_NRM_WR:
                state_next = status.idx_last_cap ? exp3_pkg::ST_DONE : exp3_pkg::ST_NRM_REQ;
            exp3_pkg::ST_RW_REQ:
                state_next = status.arm_ok ? exp3_pkg::ST_RW_DEN : exp3_pkg::ST_DONE;
            exp3_pkg::ST_RW_DEN:
                state_next = status.den_zero ? exp3_pkg::ST_RW_UPD : exp3_pkg::ST_RW_WAIT;
            exp3_pkg::ST_RW_WAIT:
                if (status.div_done)
                begin
                    state_next = exp3_pkg::ST_RW_UPD;
                end
            exp3_pkg::ST_RW_UPD:   state_next = exp3_pkg::ST_DONE;
            exp3_pkg::ST_DONE:
                if (status.out_free)
                begin
                    state_next = exp3_pkg::ST_IDLE;
                end
            default:               state_next = exp3_pkg::ST_IDLE;
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            exp3_pkg::ST_IDLE:
            begin
                cmd.accept  = in_valid;
                cmd.clr_idx = in_valid;
            end
            exp3_pkg::ST_MIN_USE:
            begin
                cmd.min_upd = 1'b1;
                cmd.clr_idx = status.idx_last_k;
                cmd.inc_idx = !status.idx_last_k;
            end
            exp3_pkg::ST_EXP_MUL:  cmd.exp_mul = 1'b1;
            exp3_pkg::ST_EXP_ROM:  cmd.exp_rom = 1'b1;
            exp3_pkg::ST_EXP_ACC:
            begin
                cmd.exp_acc = 1'b1;
                cmd.clr_idx = status.idx_last_k;
                cmd.inc_idx = !status.idx_last_k;
            end
            exp3_pkg::ST_NRM_DIV:  cmd.nrm_div_start = 1'b1;
            exp3_pkg::ST_NRM_WR:
            begin
                cmd.nrm_write = 1'b1;
                cmd.inc_idx   = !status.idx_last_cap;
            end
            exp3_pkg::ST_RW_DEN:
            begin
                cmd.rw_den       = 1'b1;
                cmd.rw_div_start = !status.den_zero;
            end
            exp3_pkg::ST_RW_UPD:   cmd.rw_update = 1'b1;
            exp3_pkg::ST_DONE:     cmd.out_load = status.out_free;
            default:               cmd = '0;
        endcase
    end

    assign in_stall = state_reg != exp3_pkg::ST_IDLE;

endmodule

`default_nettype wire

/* rtl/exp3_ix_arm_selector_unit.sv */
// ============================================================================
// EXP3-IX arm selector
// Exponential-weights bandit with implicit exploration: choose and reward.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per item:
//   kind 0 samples an arm from uniform_draw, kind 1 adds the loss estimate
//   of reward_value to the weight of arm_index. Each item gives exactly one
//   transaction on the output channel (out_valid / out_stall) carrying
//   chosen_arm and saturated.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are
//   always taken; they are to be issued only while the block is idle.
//   A reward item waits on the 35-step divider, which it skips with a zero
//   divisor or for an arm that is not active. A choose item with k active
//   arms of capacity N walks the active arms for the minimum, then for the
//   exponent and table lookup, then all N arms for normalisation, with a
//   35-step division per active arm and none per inactive arm. One item is
//   worked on at a time.
//   Reset clears weights and probabilities through valid bits at once, so
//   no clearing pass is needed; registers return to their defaults.
//   A finished result waits in the output register while out_stall is high;
//   the next item may be accepted meanwhile, but its result is held back
//   until the register is free.
// ============================================================================
`default_nettype none

module exp3_ix_arm_selector_unit #(
    parameter int ARM_CAPACITY = exp3_pkg::ARM_CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [3:0]  arm_index,
    input  wire logic [16:0] reward_value,
    input  wire logic [15:0] uniform_draw,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       chosen_arm,
    output logic             saturated
);

    exp3_pkg::cmd_t    cmd;
    exp3_pkg::status_t status;

    assign cfg_ready = 1'b1;

    exp3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    exp3_dp #(
        .ARM_CAPACITY (ARM_CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .arm_index    (arm_index),
        .reward_value (reward_value),
        .uniform_draw (uniform_draw),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .chosen_arm   (chosen_arm),
        .saturated    (saturated)
    );

endmodule

`default_nettype wire

/* test/exp3_ix_checker.sv */
// ----------------------------------------------------------------------------
// EXP3-IX arm selector checker
// Watches the configuration, input and output channels of the arm selector.
// It keeps its own copy of the weights, probabilities and registers, predicts
// the result of every accepted transaction and compares each returned result
// with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exp3_ix_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [3:0]  arm_index,
    input  logic [16:0] reward_value,
    input  logic [15:0] uniform_draw,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  chosen_arm,
    input  logic        saturated,
    output int          errors,
    output int          pending,
    output int          cfg_count,
    output int          in_count,
    output int          out_count,
    output int          sat_count
);

    localparam int ARMS = 16;

    typedef struct packed {
        logic [3:0] arm;
        logic       sat;
    } verdict_t;

    logic [16:0] decay_rom [1024];
    logic [31:0] loss_sum [ARMS];
    logic [16:0] pick_prob [ARMS];
    logic [15:0] eta;
    logic [15:0] gamma;
    logic [4:0]  arms_reg;
    verdict_t    awaited [$];

    // Rounded Q0.32 product used to build the decay table.
    function automatic longint unsigned round_q32(longint unsigned a, longint unsigned b);
        longint unsigned p;
        p = a * b;
        return (p >> 32) + ((p >> 31) & 1);
    endfunction

    initial
    begin
        longint unsigned acc;
        longint unsigned step;
        for (int j = 0; j < 1024; j++)
        begin
            acc  = 64'h1_0000_0000;
            step = 64'd4228380000;
            for (int b = 0; b < 10; b++)
            begin
                if ((j >> b) & 1)
                    acc = round_q32(acc, step);
                step = round_q32(step, step);
            end
            decay_rom[j] = 17'((acc + 64'h8000) >> 16);
        end
    end

    // Works out the result of one transaction and updates the arm state.
    function automatic verdict_t select_or_reward(logic k_in, logic [3:0] arm,
                                                  logic [16:0] reward, logic [15:0] draw);
        verdict_t        v;
        int              k;
        logic [31:0]     wmin;
        longint unsigned arg;
        longint unsigned total;
        longint unsigned run;
        longint unsigned num;
        longint unsigned den;
        longint unsigned est;
        longint unsigned w [ARMS];
        logic            found;
        v = '0;
        k = (arms_reg == 0) ? 1 : (arms_reg > ARMS) ? ARMS : int'(arms_reg);
        if (k_in == 1'b0)
        begin
            wmin = loss_sum[0];
            for (int i = 1; i < k; i++)
                if (loss_sum[i] < wmin)
                    wmin = loss_sum[i];
            total = 0;
            for (int i = 0; i < k; i++)
            begin
                arg  = longint'(eta) * longint'(loss_sum[i] - wmin);
                w[i] = ((arg >> 26) >= 1024) ? 0 : longint'(decay_rom[arg >> 26]);
                total += w[i];
            end
            for (int i = 0; i < ARMS; i++)
                pick_prob[i] = (i < k && total != 0) ?
                               17'((w[i] * 65536 + total / 2) / total) : 17'd0;
            v.arm = 4'(k - 1);
            run   = 0;
            found = 1'b0;
            for (int i = 0; i < k; i++)
            begin
                run += pick_prob[i];
                if (!found && run > draw)
                begin
                    v.arm = 4'(i);
                    found = 1'b1;
                end
            end
        end
        else if (int'(arm) < k)
        begin
            num = longint'(65536 - ((reward > 65536) ? 65536 : int'(reward))) << 16;
            den = longint'(pick_prob[arm]) + longint'(gamma);
            if (den == 0)
            begin
                est   = 64'hFFFF_FFFF;
                v.sat = 1'b1;
            end
            else
            begin
                est = num / den;
                if (est > 64'hFFFF_FFFF)
                begin
                    est   = 64'hFFFF_FFFF;
                    v.sat = 1'b1;
                end
            end
            total = longint'(loss_sum[arm]) + est;
            if (total > 64'hFFFF_FFFF)
            begin
                total = 64'hFFFF_FFFF;
                v.sat = 1'b1;
            end
            loss_sum[arm] = total[31:0];
        end
        return v;
    endfunction

    // Channel monitor: registers, predictions and comparisons.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            eta      <= exp3_pkg::LEARNING_RATE_RST;
            gamma    <= exp3_pkg::EXPLORATION_BIAS_RST;
            arms_reg <= exp3_pkg::ACTIVE_ARMS_RST;
            for (int i = 0; i < ARMS; i++)
            begin
                loss_sum[i]  = '0;
                pick_prob[i] = '0;
            end
            awaited.delete();
            errors    <= 0;
            pending   <= 0;
            cfg_count <= 0;
            in_count  <= 0;
            out_count <= 0;
            sat_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    exp3_pkg::CFG_LEARNING_RATE:    eta      <= cfg_data;
                    exp3_pkg::CFG_EXPLORATION_BIAS: gamma    <= cfg_data;
                    exp3_pkg::CFG_ACTIVE_ARMS:      arms_reg <= cfg_data[4:0];
                    default: ;
                endcase
                cfg_count <= cfg_count + 1;
            end
            if (out_valid && !out_stall)
            begin
                out_count <= out_count + 1;
                if (saturated)
                    sat_count <= sat_count + 1;
                if (awaited.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: unexpected result arm=%0d sat=%0b",
                                 $realtime, chosen_arm, saturated);
                    errors <= errors + 1;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (want.arm !== chosen_arm || want.sat !== saturated)
                    begin
                        if (errors < 10)
                            $display("%0t: mismatch arm exp=%0d got=%0d, sat exp=%0b got=%0b",
                                     $realtime, want.arm, chosen_arm, want.sat, saturated);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                awaited.insert(awaited.size(),
                               select_or_reward(kind, arm_index, reward_value,
                                                uniform_draw));
                in_count <= in_count + 1;
            end
            pending <= awaited.size();
        end
    end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// EXP3-IX arm selector testbench
// Drives directed and random choose and reward transactions through several
// register settings, with random idle bursts on both channels, and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = 1'b0;
    logic [3:0]  arm_index = '0;
    logic [16:0] reward_value = '0;
    logic [15:0] uniform_draw = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  chosen_arm;
    logic        saturated;

    int errors, pending, cfg_count, in_count, out_count, sat_count;
    int chooses, rewards, idle_cycles, stall_left;
    logic calm = 1'b0;
    int   live_arms;

    always #6 clk = ~clk;

    exp3_ix_arm_selector_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .arm_index(arm_index),
        .reward_value(reward_value), .uniform_draw(uniform_draw),
        .out_valid(out_valid), .out_stall(out_stall),
        .chosen_arm(chosen_arm), .saturated(saturated)
    );

    exp3_ix_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .arm_index(arm_index),
        .reward_value(reward_value), .uniform_draw(uniform_draw),
        .out_valid(out_valid), .out_stall(out_stall),
        .chosen_arm(chosen_arm), .saturated(saturated),
        .errors(errors), .pending(pending), .cfg_count(cfg_count),
        .in_count(in_count), .out_count(out_count), .sat_count(sat_count)
    );

    // Receiver stalls in random bursts, none once the run turns calm.
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (!calm && $urandom_range(0, 5) == 0)
            stall_left <= $urandom_range(1, 4);
        out_stall <= (stall_left > 0) && !calm;
    end

    // Watchdog on cycles with no transaction on any channel.
    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 6000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        int seen;
        seen = cfg_count;
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(negedge clk); while (cfg_count == seen);
        cfg_valid = 1'b0;
    endtask

    // Registers change only with nothing in flight.
    task automatic set_regs(logic [15:0] rate, logic [15:0] bias, logic [15:0] arms);
        wait_drained();
        write_reg(exp3_pkg::CFG_LEARNING_RATE, rate);
        write_reg(exp3_pkg::CFG_EXPLORATION_BIAS, bias);
        write_reg(exp3_pkg::CFG_ACTIVE_ARMS, arms);
        live_arms = (arms[4:0] == 0) ? 1 : (arms[4:0] > 16) ? 16 : int'(arms[4:0]);
    endtask

    task automatic send(logic k, logic [3:0] arm, logic [16:0] reward, logic [15:0] draw);
        int seen;
        if (!calm && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) @(negedge clk);
        seen = in_count;
        in_valid     = 1'b1;
        kind         = k;
        arm_index    = arm;
        reward_value = reward;
        uniform_draw = draw;
        do @(negedge clk); while (in_count == seen);
        in_valid = 1'b0;
        if (k) rewards++; else chooses++;
    endtask

    // Random traffic: mostly rewards to live arms with varied losses.
    task automatic random_items(int n);
        logic [16:0] r;
        logic [3:0]  arm;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 7))
                0:       r = 17'($urandom_range(65537, 131071));
                1:       r = 17'd0;
                2:       r = 17'd65536;
                default: r = 17'($urandom_range(0, 65536));
            endcase
            arm = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, live_arms - 1));
            if ($urandom_range(0, 9) < 3)
                send(1'b0, 4'($urandom), r, ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom));
            else
                send(1'b1, arm, r, 16'($urandom));
        end
    endtask

    initial
    begin
        chooses = 0;
        rewards = 0;
        live_arms = 16;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: register defaults, draw extremes, reward extremes.
        send(1'b0, 4'd0, 17'd0, 16'd0);
        send(1'b0, 4'd15, 17'h1FFFF, 16'hFFFF);
        send(1'b1, 4'd0, 17'd0, 16'd0);
        send(1'b1, 4'd1, 17'd65536, 16'd0);
        send(1'b1, 4'd2, 17'h1FFFF, 16'd0);
        send(1'b0, 4'd0, 17'd0, 16'd32768);

        // Equal weights at zero rate; reward for an arm that is not live.
        set_regs(16'd0, 16'd0, 16'd4);
        send(1'b0, 4'd0, 17'd0, 16'hFFFF);
        send(1'b1, 4'd7, 17'd0, 16'd0);
        send(1'b0, 4'd0, 17'd0, 16'd0);

        // Zero divisor on an arm left at probability zero, then weight overflow.
        set_regs(16'hFFFF, 16'd0, 16'd16);
        send(1'b1, 4'd9, 17'd0, 16'd0);
        send(1'b1, 4'd9, 17'd0, 16'd0);
        send(1'b0, 4'd0, 17'd0, 16'd0);
        send(1'b0, 4'd0, 17'd0, 16'd40000);

        // Active count of zero, rewards to arms that are not active and to arm 0.
        set_regs(16'hFFFF, 16'd1, 16'd0);
        send(1'b1, 4'd5, 17'd0, 16'd0);
        send(1'b0, 4'd0, 17'd0, 16'd12345);
        send(1'b1, 4'd0, 17'd0, 16'd0);
        send(1'b1, 4'd3, 17'd100, 16'd0);

        // Active count above capacity, smallest rate.
        set_regs(16'd1, 16'hFFFF, 16'd31);
        send(1'b0, 4'd0, 17'd0, 16'd65000);
        send(1'b1, 4'd15, 17'd1, 16'd0);
        send(1'b1, 4'd8, 17'h10000, 16'd0);

        // Random phases, mostly with few arms so that choices stay short.
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0:       set_regs(16'd6554, 16'd13107, 16'd16);
                1:       set_regs(16'hFFFF, 16'd0, 16'd2);
                2:       set_regs(16'd0, 16'hFFFF, 16'd1);
                default: set_regs(16'($urandom), ($urandom_range(0, 3) == 0) ?
                                  16'($urandom_range(0, 8)) : 16'($urandom),
                                  16'($urandom_range(2, 6)));
            endcase
            random_items(ph == 0 ? 60 : 150);
            if (ph == 4)
                wait_drained();
        end

        // Final stretch without idling on either side.
        calm = 1'b1;
        set_regs(16'd20000, 16'd3000, 16'd3);
        random_items(150);

        wait_drained();
        repeat (60) @(negedge clk);
        $display("Run covered %0d choose and %0d reward transactions, %0d results saturated.",
                 chooses, rewards, sat_count);
        $display("Register settings swept rate, bias and arm count across their extremes.");
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
